// ===== hw/rtl/svna_pkg.sv =====
// Shared types and constants for the smooth vertex normal accumulator.
// No dependencies; used by svna_front, svna_back and the top level.
`timescale 1ns / 1ps

package svna_pkg;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 16;
    localparam int SUM_W  = 48;
    localparam int CRS_W  = 35;   // one cross-product component
    localparam int NRM_W  = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        idx_a;
        logic [IDX_W-1:0]        idx_b;
        logic [IDX_W-1:0]        idx_c;
        logic                    a_ok;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } cmd_t;

endpackage

// ===== hw/rtl/smooth_vertex_normal_accumulator.sv =====
// A read scales the sums so the largest magnitude has 30 bits, one bit a step,
// takes a bit-serial square root and divides each component in turn; a zero sum
// or an index out of range goes straight to the output.
// The back end takes one item at a time; a 4-word queue decouples the input.
// Reset (rst_n, asynchronous): clears control; then the normal sums are swept
// to zero, one vertex a cycle, with s_axis_tready low.
`timescale 1ns / 1ps

module smooth_vertex_normal_accumulator #(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // index_a, index_b, index_c, pos_x, pos_y, pos_z, pad
    input  logic [1:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // vertex_index, normal_x, normal_y, normal_z, pad
    output logic        m_axis_tuser   // degenerate
);

    svna_pkg::cmd_t in_cmd, q_cmd;
    logic q_valid, q_pop, clr_busy;
    logic [svna_pkg::IDX_W-1:0] out_index;
    logic signed [svna_pkg::NRM_W-1:0] out_nx, out_ny, out_nz;

    always_comb
    begin
        in_cmd.kind  = s_axis_tuser;
        in_cmd.idx_a = s_axis_tdata[9:0];
        in_cmd.idx_b = s_axis_tdata[19:10];
        in_cmd.idx_c = s_axis_tdata[29:20];
        in_cmd.a_ok  = 1'b0;
        in_cmd.pos_x = s_axis_tdata[45:30];
        in_cmd.pos_y = s_axis_tdata[61:46];
        in_cmd.pos_z = s_axis_tdata[77:62];
    end

    svna_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .clr_busy (clr_busy),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    svna_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .clr_busy  (clr_busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (out_index),
        .out_nx    (out_nx),
        .out_ny    (out_ny),
        .out_nz    (out_nz),
        .out_degen (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, out_nz, out_ny, out_nx, out_index};

endmodule

// ===== hw/rtl/svna_front.sv =====
// Front end: accepts words, drops those with no effect and queues the rest.
// Depends on svna_pkg.
`timescale 1ns / 1ps

module svna_front #(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  svna_pkg::cmd_t            in_cmd,
    input  logic                      clr_busy,
    output logic                      q_valid,
    output svna_pkg::cmd_t            q_cmd,
    input  logic                      q_pop
);

    localparam int CNT_W = svna_pkg::Q_PTR_W + 1;

    svna_pkg::cmd_t q_mem [svna_pkg::Q_DEPTH];
    svna_pkg::cmd_t push_cmd;
    logic [svna_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic ok_a, ok_b, ok_c, keep, push;

    assign ok_a = 17'(in_cmd.idx_a) < 17'(VERTEX_DEPTH);
    assign ok_b = 17'(in_cmd.idx_b) < 17'(VERTEX_DEPTH);
    assign ok_c = 17'(in_cmd.idx_c) < 17'(VERTEX_DEPTH);

    // drop unused codes, stray loads and triangles with a corner out of range
    always_comb
    begin
        unique case (in_cmd.kind)
            svna_pkg::OP_LOAD: keep = ok_a;
            svna_pkg::OP_TRI:  keep = ok_a & ok_b & ok_c;
            svna_pkg::OP_READ: keep = 1'b1;
            default:           keep = 1'b0;
        endcase
    end

    always_comb
    begin
        push_cmd      = in_cmd;
        push_cmd.a_ok = ok_a;
    end

    assign in_ready = (count_reg != CNT_W'(svna_pkg::Q_DEPTH)) && !clr_busy;
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = count_reg != '0;
    assign q_cmd    = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/svna_back.sv =====
// Back end: vertex memories, cross product, saturating sums and normalizer.
// Depends on svna_pkg; fed by svna_front through its queue.
`timescale 1ns / 1ps

module svna_back #(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  svna_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    output logic                          clr_busy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [svna_pkg::IDX_W-1:0]    out_index,
    output logic signed [svna_pkg::NRM_W-1:0] out_nx,
    output logic signed [svna_pkg::NRM_W-1:0] out_ny,
    output logic signed [svna_pkg::NRM_W-1:0] out_nz,
    output logic                          out_degen
);

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int SW = svna_pkg::SUM_W;
    localparam int CW = svna_pkg::CRS_W;
    localparam int PW = svna_pkg::POS_W;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_LOAD  = 5'd2;
    localparam logic [4:0] S_TRA   = 5'd3;
    localparam logic [4:0] S_TRB   = 5'd4;
    localparam logic [4:0] S_TRC   = 5'd5;
    localparam logic [4:0] S_TE    = 5'd6;
    localparam logic [4:0] S_MUL   = 5'd7;
    localparam logic [4:0] S_CRD   = 5'd8;
    localparam logic [4:0] S_CWR   = 5'd9;
    localparam logic [4:0] S_RRD   = 5'd10;
    localparam logic [4:0] S_RMAG  = 5'd11;
    localparam logic [4:0] S_MAX   = 5'd12;
    localparam logic [4:0] S_NORM  = 5'd13;
    localparam logic [4:0] S_SQ    = 5'd14;
    localparam logic [4:0] S_SQRT  = 5'd15;
    localparam logic [4:0] S_DINIT = 5'd16;
    localparam logic [4:0] S_DIV   = 5'd17;
    localparam logic [4:0] S_DFIN  = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;

    logic [4:0] state_reg, state_next;

    // memories
    logic [3*PW-1:0] pos_mem [VERTEX_DEPTH];
    logic [3*SW-1:0] sum_mem [VERTEX_DEPTH];
    logic [3*PW-1:0] pos_q_reg;
    logic [3*SW-1:0] sum_q_reg;
    logic            pos_we, sum_we;
    logic [AW-1:0]   pos_raddr, sum_raddr, sum_waddr;
    logic [3*SW-1:0] sum_wdata;

    svna_pkg::cmd_t cmd_reg;
    logic [AW-1:0]  clr_reg;
    logic [AW-1:0]  addr_a, addr_b, addr_c, corner_addr;
    logic [16:0]    ext_a, ext_b, ext_c;
    logic [1:0]     corner_reg;

    // triangle datapath
    logic signed [PW-1:0] p0x_reg, p0y_reg, p0z_reg, p1x_reg, p1y_reg, p1z_reg;
    logic signed [PW:0]   e0x_reg, e0y_reg, e0z_reg, e1x_reg, e1y_reg, e1z_reg;
    logic signed [PW:0]   mul_a, mul_b;
    logic signed [2*PW+1:0] prod_reg, tmp_reg;
    logic signed [CW-1:0] nx_reg, ny_reg, nz_reg;
    logic [2:0]           k_reg;

    // normalizer datapath
    logic [SW-1:0]  m_reg [3];
    logic [2:0]     neg_reg;
    logic [SW-1:0]  mx_reg;
    logic [SW-1:0]  mx_cur;
    logic [59:0]    sqp_reg;
    logic [61:0]    sq_reg;
    logic [62:0]    sx_reg, sres_reg, sbit_reg;
    logic [62:0]    strial;
    logic [4:0]     it_reg;
    logic [46:0]    num_reg, dsh_reg;
    logic [16:0]    quo_reg;
    logic [15:0]    qc;
    logic [PW-1:0]  res_reg [3];
    logic           degen_reg;

    // output register
    logic                   ov_reg;
    logic [svna_pkg::IDX_W-1:0] oidx_reg;
    logic [PW-1:0]          onx_reg, ony_reg, onz_reg;
    logic                   odeg_reg;

    assign ext_a  = 17'(cmd_reg.idx_a);
    assign ext_b  = 17'(cmd_reg.idx_b);
    assign ext_c  = 17'(cmd_reg.idx_c);
    assign addr_a = ext_a[AW-1:0];
    assign addr_b = ext_b[AW-1:0];
    assign addr_c = ext_c[AW-1:0];

    always_comb
    begin
        unique case (corner_reg)
            2'd0:    corner_addr = addr_a;
            2'd1:    corner_addr = addr_b;
            default: corner_addr = addr_c;
        endcase
    end

    assign clr_busy = state_reg == S_CLR;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // memory port control
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                              input logic signed [CW-1:0] n);
        logic signed [SW:0] r;
        begin
            r = $signed({s[SW-1], s}) + (SW+1)'(n);
            if (r[SW] != r[SW-1])
                sat_add = r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            else
                sat_add = r[SW-1:0];
        end
    endfunction

    always_comb
    begin
        pos_we    = state_reg == S_LOAD;
        sum_we    = 1'b0;
        sum_waddr = addr_a;
        sum_wdata = '0;
        pos_raddr = addr_a;
        sum_raddr = addr_a;
        priority case (state_reg)
            S_CLR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
            end
            S_LOAD:
                sum_we = 1'b1;
            S_TRB:   pos_raddr = addr_b;
            S_TRC:   pos_raddr = addr_c;
            S_CRD:   sum_raddr = corner_addr;
            S_CWR:
            begin
                sum_we    = 1'b1;
                sum_waddr = corner_addr;
                sum_wdata = {sat_add(sum_q_reg[3*SW-1:2*SW], nz_reg),
                             sat_add(sum_q_reg[2*SW-1:SW], ny_reg),
                             sat_add(sum_q_reg[SW-1:0], nx_reg)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[addr_a] <= {cmd_reg.pos_z, cmd_reg.pos_y, cmd_reg.pos_x};
        pos_q_reg <= pos_mem[pos_raddr];
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_q_reg <= sum_mem[sum_raddr];
    end

    // shared cross-product multiplier, one partial product a cycle
    always_comb
    begin
        unique case (k_reg)
            3'd0:    begin mul_a = e0y_reg; mul_b = e1z_reg; end
            3'd1:    begin mul_a = e0z_reg; mul_b = e1y_reg; end
            3'd2:    begin mul_a = e0z_reg; mul_b = e1x_reg; end
            3'd3:    begin mul_a = e0x_reg; mul_b = e1z_reg; end
            3'd4:    begin mul_a = e0x_reg; mul_b = e1y_reg; end
            default: begin mul_a = e0y_reg; mul_b = e1x_reg; end
        endcase
    end

    assign strial = sres_reg + sbit_reg;

    assign mx_cur = (m_reg[0] > m_reg[1])
                    ? ((m_reg[0] > m_reg[2]) ? m_reg[0] : m_reg[2])
                    : ((m_reg[1] > m_reg[2]) ? m_reg[1] : m_reg[2]);

    always_comb
    begin
        if (neg_reg[corner_reg])
            qc = (quo_reg > 17'd32768) ? 16'h8000 : 16'(-quo_reg);
        else
            qc = (quo_reg > 17'd32767) ? 16'h7FFF : quo_reg[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:   if (clr_reg == AW'(VERTEX_DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:
                if (q_valid)
                begin
                    unique case (q_cmd.kind)
                        svna_pkg::OP_LOAD: state_next = S_LOAD;
                        svna_pkg::OP_TRI:  state_next = S_TRA;
                        default:           state_next = q_cmd.a_ok ? S_RRD : S_OUT;
                    endcase
                end
            S_LOAD:  state_next = S_IDLE;
            S_TRA:   state_next = S_TRB;
            S_TRB:   state_next = S_TRC;
            S_TRC:   state_next = S_TE;
            S_TE:    state_next = S_MUL;
            S_MUL:   if (k_reg == 3'd6) state_next = S_CRD;
            S_CRD:   state_next = S_CWR;
            S_CWR:   state_next = (corner_reg == 2'd2) ? S_IDLE : S_CRD;
            S_RRD:   state_next = S_RMAG;
            S_RMAG:  state_next = S_MAX;
            S_MAX:   state_next = (mx_cur == '0) ? S_OUT : S_NORM;
            S_NORM:
                if (mx_reg[SW-1:30] == '0 && mx_reg[29])
                    state_next = S_SQ;
            S_SQ:    if (k_reg == 3'd3) state_next = S_SQRT;
            S_SQRT:  if (it_reg == 5'd31) state_next = S_DINIT;
            S_DINIT: state_next = S_DIV;
            S_DIV:   if (it_reg == 5'd16) state_next = S_DFIN;
            S_DFIN:  state_next = (corner_reg == 2'd2) ? S_OUT : S_DINIT;
            S_OUT:   if (!ov_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_OUT && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg    <= q_cmd;
                corner_reg <= '0;
                k_reg      <= '0;
                degen_reg  <= 1'b1;
                res_reg[0] <= '0;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
            end
            S_TRB:
                {p0z_reg, p0y_reg, p0x_reg} <= pos_q_reg;
            S_TRC:
                {p1z_reg, p1y_reg, p1x_reg} <= pos_q_reg;
            S_TE:
            begin
                e0x_reg <= (PW+1)'(p1x_reg) - (PW+1)'(p0x_reg);
                e0y_reg <= (PW+1)'(p1y_reg) - (PW+1)'(p0y_reg);
                e0z_reg <= (PW+1)'(p1z_reg) - (PW+1)'(p0z_reg);
                e1x_reg <= (PW+1)'($signed(pos_q_reg[PW-1:0])) - (PW+1)'(p0x_reg);
                e1y_reg <= (PW+1)'($signed(pos_q_reg[2*PW-1:PW])) - (PW+1)'(p0y_reg);
                e1z_reg <= (PW+1)'($signed(pos_q_reg[3*PW-1:2*PW])) - (PW+1)'(p0z_reg);
            end
            S_MUL:
            begin
                k_reg    <= k_reg + 1'b1;
                prod_reg <= mul_a * mul_b;
                unique case (k_reg)
                    3'd2:    nx_reg  <= CW'(tmp_reg) - CW'(prod_reg);
                    3'd4:    ny_reg  <= CW'(tmp_reg) - CW'(prod_reg);
                    3'd6:    nz_reg  <= CW'(tmp_reg) - CW'(prod_reg);
                    default: tmp_reg <= prod_reg;
                endcase
            end
            S_CWR:
                corner_reg <= corner_reg + 1'b1;
            S_RMAG:
            begin
                neg_reg <= {sum_q_reg[3*SW-1], sum_q_reg[2*SW-1], sum_q_reg[SW-1]};
                m_reg[0] <= sum_q_reg[SW-1] ? -sum_q_reg[SW-1:0] : sum_q_reg[SW-1:0];
                m_reg[1] <= sum_q_reg[2*SW-1] ? -sum_q_reg[2*SW-1:SW]
                                              : sum_q_reg[2*SW-1:SW];
                m_reg[2] <= sum_q_reg[3*SW-1] ? -sum_q_reg[3*SW-1:2*SW]
                                              : sum_q_reg[3*SW-1:2*SW];
            end
            S_MAX:
            begin
                mx_reg <= mx_cur;
                k_reg  <= '0;
                sq_reg <= '0;
            end
            S_NORM:
                // bring the largest magnitude to exactly 30 bits, one bit a step
                if (mx_reg[SW-1:30] != '0)
                begin
                    mx_reg   <= mx_reg >> 1;
                    m_reg[0] <= m_reg[0] >> 1;
                    m_reg[1] <= m_reg[1] >> 1;
                    m_reg[2] <= m_reg[2] >> 1;
                end
                else if (!mx_reg[29])
                begin
                    mx_reg   <= mx_reg << 1;
                    m_reg[0] <= m_reg[0] << 1;
                    m_reg[1] <= m_reg[1] << 1;
                    m_reg[2] <= m_reg[2] << 1;
                end
            S_SQ:
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg != 3'd3)
                    sqp_reg <= m_reg[k_reg[1:0]][29:0] * m_reg[k_reg[1:0]][29:0];
                if (k_reg != 3'd0)
                    sq_reg <= sq_reg + 62'(sqp_reg);
                sx_reg   <= 63'(sq_reg + 62'(sqp_reg));
                sres_reg <= '0;
                sbit_reg <= {1'b1, 62'd0};
                it_reg   <= '0;
            end
            S_SQRT:
            begin
                it_reg   <= it_reg + 1'b1;
                sbit_reg <= sbit_reg >> 2;
                if (sx_reg >= strial)
                begin
                    sx_reg   <= sx_reg - strial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                    sres_reg <= sres_reg >> 1;
                corner_reg <= '0;
            end
            S_DINIT:
            begin
                num_reg <= {2'b0, m_reg[corner_reg][29:0], 15'd0}
                           + 47'(sres_reg[31:1]);
                dsh_reg <= {sres_reg[30:0], 16'd0};
                quo_reg <= '0;
                it_reg  <= '0;
            end
            S_DIV:
            begin
                it_reg  <= it_reg + 1'b1;
                dsh_reg <= dsh_reg >> 1;
                if (num_reg >= dsh_reg)
                begin
                    num_reg <= num_reg - dsh_reg;
                    quo_reg <= {quo_reg[15:0], 1'b1};
                end
                else
                    quo_reg <= {quo_reg[15:0], 1'b0};
            end
            S_DFIN:
            begin
                res_reg[corner_reg] <= qc;
                corner_reg          <= corner_reg + 1'b1;
                degen_reg           <= 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ov_reg || out_ready))
        begin
            oidx_reg <= cmd_reg.idx_a;
            onx_reg  <= res_reg[0];
            ony_reg  <= res_reg[1];
            onz_reg  <= res_reg[2];
            odeg_reg <= degen_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_index = oidx_reg;
    assign out_nx    = onx_reg;
    assign out_ny    = ony_reg;
    assign out_nz    = onz_reg;
    assign out_degen = odeg_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE) && q_valid)
        else $error("queue popped outside idle");

    a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CWR) |=> (state_reg == S_CRD || state_reg == S_IDLE))
        else $error("corner update sequence broken");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DINIT) |-> (sres_reg[62:31] == '0 && sres_reg[30:29] != 2'b00))
        else $error("vector length outside normalized range");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && odeg_reg) |-> (onx_reg == '0 && ony_reg == '0 && onz_reg == '0))
        else $error("degenerate result with nonzero normal");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for smooth_vertex_normal_accumulator: directed table, then random words.
// Depends on svna_pkg and the RTL only; results are checked against a built-in normal predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH     = 1024;
    localparam int WATCHDOG  = 6000;
    localparam int HOLD_LEN  = 400;
    localparam int N_RANDOM  = 1080;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef logic [svna_pkg::IDX_W-1:0]        idx_t;
    typedef logic signed [svna_pkg::POS_W-1:0] pos_t;
    typedef logic signed [svna_pkg::NRM_W-1:0] nrm_t;

    typedef struct packed {
        idx_t vidx;
        nrm_t nx;
        nrm_t ny;
        nrm_t nz;
        logic degen;
    } normal_t;

    typedef struct {
        logic [1:0] op;
        idx_t       a;
        idx_t       b;
        idx_t       c;
        pos_t       x;
        pos_t       y;
        pos_t       z;
        bit         typed;
        normal_t    want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;  // index_a, index_b, index_c, pos_x, pos_y, pos_z, pad
    logic [1:0]  s_axis_tuser = '0;  // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;       // vertex_index, normal_x, normal_y, normal_z, pad
    logic        m_axis_tuser;       // degenerate

    // predictor state
    pos_t   vpos [DEPTH][3];
    longint nsum [DEPTH][3];
    bit     loaded [DEPTH];
    idx_t   loaded_list [$];

    normal_t pending_normals [$];
    row_t    table_rows [$];

    int  mismatches = 0;
    int  n_items = 0, n_tris = 0, n_reads = 0, n_degen = 0;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;

    smooth_vertex_normal_accumulator #(.VERTEX_DEPTH(DEPTH)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    function automatic longint sat_sum(longint acc, longint inc);
        longint r;
        r = acc + inc;
        if (r > SUM_HI)
            r = SUM_HI;
        if (r < SUM_LO)
            r = SUM_LO;
        return r;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] x);
        bit [63:0] res;
        bit [63:0] probe;
        res = 0;
        probe = 64'h1 << 62;
        while (probe > x)
            probe >>= 2;
        while (probe != 0) begin
            if (x >= res + probe) begin
                x -= res + probe;
                res = (res >> 1) + probe;
            end
            else
                res >>= 1;
            probe >>= 2;
        end
        return res;
    endfunction

    function automatic normal_t unit_normal(idx_t v);
        normal_t   r;
        bit [63:0] m [3];
        bit [63:0] mx, sq, len, q;
        int        nbits;
        nrm_t      comp [3];
        r.vidx = v;
        mx = 0;
        nbits = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = nsum[v][i] < 0 ? 64'(-nsum[v][i]) : 64'(nsum[v][i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0) begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
            return r;
        end
        while (nbits < 64 && (mx >> nbits) != 0)
            nbits++;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            if (nbits > 30)
                m[i] >>= (nbits - 30);
            else
                m[i] <<= (30 - nbits);
            sq += m[i] * m[i];
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 64'd32768 + len / 2) / len;
            if (nsum[v][i] < 0) begin
                if (q > 32768)
                    q = 32768;
                comp[i] = nrm_t'(-$signed(q[16:0]));
            end
            else begin
                if (q > 32767)
                    q = 32767;
                comp[i] = q[15:0];
            end
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.degen = 1'b0;
        return r;
    endfunction

    // Advance the predictor by one word; returns 1 when a normal comes back.
    function automatic bit predict_word(row_t w, output normal_t res);
        longint e0 [3], e1 [3], cr [3];
        idx_t   corner [3];
        res = '0;
        case (w.op)
            svna_pkg::OP_LOAD: begin
                vpos[w.a][0] = w.x; vpos[w.a][1] = w.y; vpos[w.a][2] = w.z;
                for (int i = 0; i < 3; i++)
                    nsum[w.a][i] = 0;
                if (!loaded[w.a]) begin
                    loaded[w.a] = 1'b1;
                    loaded_list.push_back(w.a);
                end
                return 1'b0;
            end
            svna_pkg::OP_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    e0[i] = longint'(vpos[w.b][i]) - longint'(vpos[w.a][i]);
                    e1[i] = longint'(vpos[w.c][i]) - longint'(vpos[w.a][i]);
                end
                cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
                cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
                cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
                corner[0] = w.a; corner[1] = w.b; corner[2] = w.c;
                // a repeated corner takes the product once per mention
                for (int k = 0; k < 3; k++)
                    for (int i = 0; i < 3; i++)
                        nsum[corner[k]][i] = sat_sum(nsum[corner[k]][i], cr[i]);
                return 1'b0;
            end
            svna_pkg::OP_READ: begin
                res = unit_normal(w.a);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_word(row_t w);
        normal_t res;
        if (!no_idle && $urandom_range(0, 99) < 28) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.op;
        s_axis_tdata  <= {2'b00, w.z, w.y, w.x, w.c, w.b, w.a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_items++;
        if (w.op == svna_pkg::OP_TRI)
            n_tris++;
        if (predict_word(w, res)) begin
            n_reads++;
            pending_normals.push_back(w.typed ? w.want : res);
        end
    endtask

    task automatic add_row(logic [1:0] op, int a, int b, int c, int x, int y, int z,
                           bit typed = 0, int nx = 0, int ny = 0, int nz = 0, bit dg = 0);
        row_t r;
        r.op = op; r.a = idx_t'(a); r.b = idx_t'(b); r.c = idx_t'(c);
        r.x = pos_t'(x); r.y = pos_t'(y); r.z = pos_t'(z);
        r.typed = typed;
        r.want.vidx = idx_t'(a);
        r.want.nx = nrm_t'(nx); r.want.ny = nrm_t'(ny); r.want.nz = nrm_t'(nz);
        r.want.degen = dg;
        table_rows.push_back(r);
    endtask

    function automatic idx_t pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    function automatic pos_t rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return pos_t'($urandom_range(0, 128) - 64);
            default: return pos_t'($urandom());
        endcase
    endfunction

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end

    always @(posedge clk) begin
        normal_t want;
        normal_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.vidx = m_axis_tdata[9:0];
            got.nx = m_axis_tdata[25:10];
            got.ny = m_axis_tdata[41:26];
            got.nz = m_axis_tdata[57:42];
            got.degen = m_axis_tuser;
            if (got.degen)
                n_degen++;
            if (pending_normals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal word: vertex %0d", got.vidx);
            end
            else begin
                want = pending_normals.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("normal mismatch: want v%0d (%0d %0d %0d) dg%0b, %s",
                                 want.vidx, want.nx, want.ny, want.nz, want.degen,
                                 $sformatf("got v%0d (%0d %0d %0d) dg%0b",
                                           got.vidx, got.nx, got.ny, got.nz, got.degen));
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        row_t w;
        int   r;
        for (int i = 0; i < DEPTH; i++)
            for (int k = 0; k < 3; k++)
                nsum[i][k] = 0;

        // never-loaded vertex reads back an empty sum
        add_row(svna_pkg::OP_READ, 5, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(svna_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0);
        add_row(svna_pkg::OP_LOAD, 1, 0, 0, 32767, 0, 0);
        add_row(svna_pkg::OP_LOAD, 2, 0, 0, 0, 32767, 0);
        add_row(svna_pkg::OP_TRI, 0, 1, 2, 0, 0, 0);
        add_row(svna_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0, 32767, 0);
        add_row(svna_pkg::OP_LOAD, 3, 0, 0, -32768, -32768, -32768);
        add_row(svna_pkg::OP_LOAD, 4, 0, 0, 32767, 32767, -32768);
        add_row(svna_pkg::OP_LOAD, 5, 0, 0, -32768, 32767, 32767);
        add_row(svna_pkg::OP_TRI, 3, 4, 5, 0, 0, 0);
        add_row(svna_pkg::OP_TRI, 5, 4, 3, 0, 0, 0);
        add_row(svna_pkg::OP_TRI, 3, 3, 4, 0, 0, 0);
        add_row(svna_pkg::OP_TRI, 0, 4, 5, 0, 0, 0);
        add_row(svna_pkg::OP_READ, 3, 0, 0, 0, 0, 0);
        add_row(svna_pkg::OP_READ, 4, 0, 0, 0, 0, 0);
        add_row(svna_pkg::OP_READ, 5, 0, 0, 0, 0, 0);
        add_row(OP_SPARE, 1023, 1023, 1023, -1, -1, -1);
        add_row(svna_pkg::OP_LOAD, 1, 0, 0, 1, -1, 1);
        add_row(svna_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(svna_pkg::OP_LOAD, 1023, 0, 0, -32768, 32767, -1);
        add_row(svna_pkg::OP_TRI, 1023, 2, 3, 0, 0, 0);
        add_row(svna_pkg::OP_READ, 1023, 0, 0, 0, 0, 0);
        add_row(svna_pkg::OP_READ, 2, 0, 0, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
            send_word(table_rows[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 300 && n < 450);
            if (n == 600)
                hold_req = 1'b1;
            if (n == 800) begin
                // hold the input until every normal has drained
                s_axis_tvalid <= 1'b0;
                while (pending_normals.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            w = '{default: '0};
            w.x = rand_pos(); w.y = rand_pos(); w.z = rand_pos();
            w.b = idx_t'($urandom()); w.c = idx_t'($urandom());
            r = $urandom_range(0, 99);
            if (r < 18) begin
                w.op = svna_pkg::OP_LOAD;
                w.a = $urandom_range(0, 3) == 0 ? idx_t'($urandom())
                                                : idx_t'($urandom_range(0, 23));
            end
            else if (r < 68) begin
                w.op = svna_pkg::OP_TRI;
                w.a = pick_loaded(); w.b = pick_loaded(); w.c = pick_loaded();
                if ($urandom_range(0, 19) == 0)
                    w.c = w.a;
            end
            else if (r < 96) begin
                w.op = svna_pkg::OP_READ;
                w.a = $urandom_range(0, 9) == 0 ? idx_t'($urandom()) : pick_loaded();
            end
            else begin
                w.op = OP_SPARE;
                w.a = idx_t'($urandom());
            end
            send_word(w);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d words: %0d triangles, %0d normal reads (%0d degenerate),",
                 n_items, n_tris, n_reads, n_degen);
        $display("with random stalls on both sides, a long output hold-off and a full drain.");
        if (mismatches == 0 && pending_normals.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/svna_pkg.sv
hw/rtl/svna_front.sv
hw/rtl/svna_back.sv
hw/rtl/smooth_vertex_normal_accumulator.sv
tb/testbench.sv
